// ===== rtl/mxm_pkg.sv =====
// ----------------------------------------------------------------------------
// mxm_pkg
// shared constants and types of the 4x4 fixed-point matrix multiplier
// ----------------------------------------------------------------------------
package mxm_pkg;

  localparam int unsigned Dim         = 4;
  localparam int unsigned IdxW        = $clog2(Dim);
  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned FracBitsDef  = 16;

  typedef logic [IdxW-1:0] idx_t;

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    StLoad  = 3'b001,
    StRun   = 3'b010,
    StDrain = 3'b100
  } mxm_state_e;

  // control that travels with the data into the multiply-accumulate lanes
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctrl_t;

endpackage

// ===== rtl/mxm_if.sv =====
// ----------------------------------------------------------------------------
// mxm_if
// valid/ready channels: column pair in, result column out
// ----------------------------------------------------------------------------
interface mxm_in_if #(
  parameter int unsigned DATA_WIDTH = mxm_pkg::DataWidthDef
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] a_row0;
  logic signed [DATA_WIDTH-1:0] a_row1;
  logic signed [DATA_WIDTH-1:0] a_row2;
  logic signed [DATA_WIDTH-1:0] a_row3;
  logic signed [DATA_WIDTH-1:0] b_row0;
  logic signed [DATA_WIDTH-1:0] b_row1;
  logic signed [DATA_WIDTH-1:0] b_row2;
  logic signed [DATA_WIDTH-1:0] b_row3;

  modport source (
    output valid, a_row0, a_row1, a_row2, a_row3, b_row0, b_row1, b_row2, b_row3,
    input  ready
  );
  modport sink (
    input  valid, a_row0, a_row1, a_row2, a_row3, b_row0, b_row1, b_row2, b_row3,
    output ready
  );
endinterface

interface mxm_out_if #(
  parameter int unsigned DATA_WIDTH = mxm_pkg::DataWidthDef
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] res_row0;
  logic signed [DATA_WIDTH-1:0] res_row1;
  logic signed [DATA_WIDTH-1:0] res_row2;
  logic signed [DATA_WIDTH-1:0] res_row3;
  logic                         last_column;

  modport source (
    output valid, res_row0, res_row1, res_row2, res_row3, last_column,
    input  ready
  );
  modport sink (
    input  valid, res_row0, res_row1, res_row2, res_row3, last_column,
    output ready
  );
endinterface

// ===== rtl/mxm_col_mem.sv =====
// ----------------------------------------------------------------------------
// mxm_col_mem
// one-column-per-entry store, one write and one registered read port
// ----------------------------------------------------------------------------
module mxm_col_mem #(
  parameter int unsigned WIDTH = mxm_pkg::Dim * mxm_pkg::DataWidthDef
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  mxm_pkg::idx_t    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  mxm_pkg::idx_t    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  import mxm_pkg::*;

  logic [WIDTH-1:0] mem_q [Dim];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mxm_mac_lanes.sv =====
// ----------------------------------------------------------------------------
// mxm_mac_lanes
// four multiply-accumulate lanes, one per result row
// ----------------------------------------------------------------------------
module mxm_mac_lanes #(
  parameter int unsigned DATA_WIDTH = mxm_pkg::DataWidthDef,
  localparam int unsigned AccW      = 2 * DATA_WIDTH + 2
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  mxm_pkg::mac_ctrl_t                          ctrl_i,
  input  logic [mxm_pkg::Dim-1:0][DATA_WIDTH-1:0]     a_col_i,
  input  logic signed [DATA_WIDTH-1:0]                b_elem_i,
  output logic [mxm_pkg::Dim-1:0][AccW-1:0]           acc_o,
  output logic                                        done_o
);
  import mxm_pkg::*;

  localparam int unsigned ProdW = 2 * DATA_WIDTH;

  logic signed [ProdW-1:0] prod_q [Dim];
  logic signed [AccW-1:0]  acc_q  [Dim];
  logic                    pv_q, pfirst_q, plast_q, done_q;

  // product stage, registered before the add
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < Dim; r++) begin
      if (ctrl_i.valid) begin
        prod_q[r] <= ProdW'($signed(a_col_i[r])) * ProdW'(b_elem_i);
      end
    end
    if (ctrl_i.valid) begin
      pfirst_q <= ctrl_i.first;
      plast_q  <= ctrl_i.last;
    end
  end

  // accumulate stage
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < Dim; r++) begin
      if (pv_q) begin
        acc_q[r] <= (pfirst_q ? '0 : acc_q[r]) + AccW'(prod_q[r]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      pv_q   <= ctrl_i.valid;
      done_q <= pv_q && plast_q;
    end
  end

  always_comb begin
    for (int r = 0; r < Dim; r++) begin
      acc_o[r] = acc_q[r];
    end
  end

  assign done_o = done_q;

endmodule

// ===== rtl/mxm_rnd_sat.sv =====
// ----------------------------------------------------------------------------
// mxm_rnd_sat
// round to nearest (ties up) and saturate the exact sums to the output format
// ----------------------------------------------------------------------------
module mxm_rnd_sat #(
  parameter int unsigned DATA_WIDTH = mxm_pkg::DataWidthDef,
  parameter int unsigned FRAC_BITS  = mxm_pkg::FracBitsDef,
  localparam int unsigned AccW      = 2 * DATA_WIDTH + 2
) (
  input  logic [mxm_pkg::Dim-1:0][AccW-1:0]       acc_i,
  output logic [mxm_pkg::Dim-1:0][DATA_WIDTH-1:0] res_o
);
  import mxm_pkg::*;

  localparam logic [AccW-1:0] Half =
    {{(AccW - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
  localparam logic signed [AccW-1:0] MaxV =
    {{(AccW - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic signed [AccW-1:0] MinV =
    {{(AccW - DATA_WIDTH + 1){1'b1}}, {(DATA_WIDTH - 1){1'b0}}};

  logic signed [AccW-1:0] sum   [Dim];
  logic signed [AccW-1:0] shft  [Dim];

  always_comb begin
    for (int r = 0; r < Dim; r++) begin
      sum[r]  = $signed(acc_i[r]) + $signed(Half);
      shft[r] = sum[r] >>> FRAC_BITS;
      if (shft[r] > MaxV) begin
        res_o[r] = MaxV[DATA_WIDTH-1:0];
      end else if (shft[r] < MinV) begin
        res_o[r] = MinV[DATA_WIDTH-1:0];
      end else begin
        res_o[r] = shft[r][DATA_WIDTH-1:0];
      end
    end
  end

endmodule

// ===== rtl/matrix4x4_multiply_unit.sv =====
// ----------------------------------------------------------------------------
// matrix4x4_multiply_unit
// 4x4 signed fixed-point matrix product, result = A times B, column-major
// ----------------------------------------------------------------------------
// Load four words, each carrying column k of A and column k of B (k = 0..3,
// in order); the unit takes them only while idle between matrices. After
// the fourth word it computes and emits the four result columns in order,
// last_column set on the fourth. Each result column takes four reads of
// the A column memory, feeding one shared bank of four multiply-accumulate
// lanes (one lane per row), followed by the product register, the
// accumulate register and the round/saturate into the output register.
// Loading of the next matrix is accepted while the last result column
// still waits at the output. Elements are rounded to nearest with ties
// toward plus infinity and saturated to the signed DATA_WIDTH range.
// ----------------------------------------------------------------------------
module matrix4x4_multiply_unit #(
  parameter int unsigned DATA_WIDTH = mxm_pkg::DataWidthDef,
  parameter int unsigned FRAC_BITS  = mxm_pkg::FracBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  mxm_in_if.sink   in_i,
  mxm_out_if.source res_o
);
  import mxm_pkg::*;

  localparam int unsigned ColW = Dim * DATA_WIDTH;
  localparam int unsigned AccW = 2 * DATA_WIDTH + 2;
  localparam idx_t        LastIdx = idx_t'(Dim - 1);

  // sequencer
  mxm_state_e state_q, state_d;
  idx_t       load_cnt_q, load_cnt_d;   // column being loaded next
  idx_t       col_q, col_d;             // result column being computed
  idx_t       step_q, step_d;           // inner-product step, picks A column

  logic in_fire, out_fire, out_free, issue, done;

  // read stage control
  logic rd_v_q, rd_first_q, rd_last_q;
  idx_t rd_sel_q;

  // column memories and lanes
  logic [Dim-1:0][DATA_WIDTH-1:0] a_wdata, b_wdata;
  logic [Dim-1:0][DATA_WIDTH-1:0] a_rd, b_rd;
  logic [Dim-1:0][AccW-1:0]       acc;
  logic [Dim-1:0][DATA_WIDTH-1:0] rnd;
  mac_ctrl_t                      mac_ctrl;

  // output register
  logic                           out_valid_q, out_valid_d;
  logic [Dim-1:0][DATA_WIDTH-1:0] res_q;
  logic                           last_q;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_valid_q && res_o.ready;
  assign out_free = !out_valid_q || out_fire;

  // loads only while idle between matrices; memories are never written
  // while a computation reads them, so no forwarding is needed
  assign in_i.ready = (state_q == StLoad);

  // a column starts only with the output register free, so its result
  // always finds room when it comes out of the pipeline
  assign issue = (state_q == StRun) && ((step_q != '0) || out_free);

  assign a_wdata = {in_i.a_row3, in_i.a_row2, in_i.a_row1, in_i.a_row0};
  assign b_wdata = {in_i.b_row3, in_i.b_row2, in_i.b_row1, in_i.b_row0};

  mxm_col_mem #(
    .WIDTH (ColW)
  ) u_a_mem (
    .clk_i   (clk_i),
    .we_i    (in_fire),
    .waddr_i (load_cnt_q),
    .wdata_i (a_wdata),
    .re_i    (issue),
    .raddr_i (step_q),
    .rdata_o (a_rd)
  );

  mxm_col_mem #(
    .WIDTH (ColW)
  ) u_b_mem (
    .clk_i   (clk_i),
    .we_i    (in_fire),
    .waddr_i (load_cnt_q),
    .wdata_i (b_wdata),
    .re_i    (issue),
    .raddr_i (col_q),
    .rdata_o (b_rd)
  );

  // read data arrives in the cycle after issue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
    end else begin
      rd_v_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_first_q <= (step_q == '0);
      rd_last_q  <= (step_q == LastIdx);
      rd_sel_q   <= step_q;
    end
  end

  assign mac_ctrl = '{valid: rd_v_q, first: rd_first_q, last: rd_last_q};

  // element k of the B column pairs with column k of A
  mxm_mac_lanes #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .a_col_i  (a_rd),
    .b_elem_i ($signed(b_rd[rd_sel_q])),
    .acc_o    (acc),
    .done_o   (done)
  );

  mxm_rnd_sat #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_rnd (
    .acc_i (acc),
    .res_o (rnd)
  );

  // sequencer next state
  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    col_d      = col_q;
    step_d     = step_q;
    unique case (state_q)
      StLoad: begin
        if (in_fire) begin
          load_cnt_d = load_cnt_q + 1'b1;
          if (load_cnt_q == LastIdx) begin
            state_d = StRun;
            col_d   = '0;
            step_d  = '0;
          end
        end
      end
      StRun: begin
        if (issue) begin
          step_d = step_q + 1'b1;
          if (step_q == LastIdx) begin
            state_d = StDrain;
          end
        end
      end
      StDrain: begin
        if (done) begin
          if (col_q == LastIdx) begin
            state_d = StLoad;
          end else begin
            state_d = StRun;
            col_d   = col_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StLoad;
      load_cnt_q <= '0;
      col_q      <= '0;
      step_q     <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      col_q      <= col_d;
      step_q     <= step_d;
    end
  end

  // output register: filled when a column's sums are complete
  always_comb begin
    out_valid_d = out_valid_q;
    if (done) begin
      out_valid_d = 1'b1;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      res_q  <= rnd;
      last_q <= (col_q == LastIdx);
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.res_row0    = $signed(res_q[0]);
  assign res_o.res_row1    = $signed(res_q[1]);
  assign res_o.res_row2    = $signed(res_q[2]);
  assign res_o.res_row3    = $signed(res_q[3]);
  assign res_o.last_column = last_q;

endmodule
